// ===== src/deque_with_key_removal_assert.svh =====
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_KEY_REMOVAL_ASSERT_SVH
`define DEQUE_WITH_KEY_REMOVAL_ASSERT_SVH

// same-cycle implication
`define DQKR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DQKR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/dqkr_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Opcodes, status codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dqkr_pkg;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_RM_KEY     = 3'd4;
	localparam logic [2:0] OP_RM_MEAN    = 3'd5;
	localparam logic [2:0] OP_CLEAR      = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = 7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SUM,
		S_PACK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic cap_pop;
		logic run_sum;
		logic run_pack;
		logic start_pack;
		logic pack_end;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic sum_done;
		logic pack_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== src/dqkr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqkr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/dqkr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one operation at a time and owns the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqkr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [2:0]    opcode,
	output logic               out_valid,
	input  wire logic          out_stall,
	output dqkr_pkg::cmd_t     cmd,
	input  wire dqkr_pkg::sts_t sts
);
	import dqkr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (opcode) inside
						OP_POP_FRONT, OP_POP_BACK: state_d = sts.empty ? S_DONE : S_POP;
						OP_RM_KEY:                 state_d = S_PACK;
						OP_RM_MEAN:                state_d = S_SUM;
						default:                   state_d = S_DONE;
					endcase
				end
			end
			S_POP: begin
				cmd.cap_pop = 1'b1;
				state_d     = S_DONE;
			end
			S_SUM: begin
				cmd.run_sum = 1'b1;
				if (sts.sum_done) begin
					cmd.start_pack = 1'b1;
					state_d        = S_PACK;
				end
			end
			S_PACK: begin
				cmd.run_pack = 1'b1;
				if (sts.pack_done) begin
					cmd.pack_end = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/dqkr_dp.sv =====
// ----------------------------------------------------------------------------
// Deque datapath
// Ring pointers, summing and compacting pipeline, result and output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqkr_dp #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dqkr_pkg::cmd_t        cmd,
	output dqkr_pkg::sts_t             sts,
	input  wire logic [2:0]            opcode,
	input  wire logic signed [31:0]    value,
	output logic signed [31:0]         popped_value,
	output logic [6:0]                 removed_count,
	output logic [1:0]                 status
);
	import dqkr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = DATA_W + CW;
	localparam int unsigned PW = DATA_W + CW + 1;

	logic [AW-1:0]       head_q;
	logic [CW-1:0]       occ_q, rd_q, wr_q;
	logic [2:0]          op_q;
	logic [31:0]         key_q;
	logic signed [SW-1:0] sum_q;
	logic                vld_s1, vld_s2;
	logic signed [PW-1:0] prod_s2;
	logic [31:0]         val_s2;
	logic [31:0]         res_pop_q;
	logic [6:0]          res_rem_q;
	logic [1:0]          res_st_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_wa, ram_ra;
	logic [31:0]          ram_wd, ram_rd;
	logic signed [31:0]   rd_sval;
	logic                 full, empty, issue, keep, pushing;
	logic [AW-1:0]        head_dec;
	logic signed [PW-1:0] sum_ext;
	logic [CW-1:0]        gone;
	logic [CW+6:0]        gone_ext;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	dqkr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	assign rd_sval   = signed'(ram_rd);
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign issue     = (cmd.run_sum || cmd.run_pack) && (rd_q < occ_q);
	assign sum_ext   = PW'(sum_q);
	assign keep      = (op_q == OP_RM_KEY) ? (val_s2 != key_q) : !(prod_s2 < sum_ext);
	assign pushing   = cmd.accept && !full
	                   && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK);
	assign gone      = occ_q - wr_q;
	assign gone_ext  = (CW+7)'(gone);

	assign sts.empty     = empty;
	assign sts.sum_done  = (rd_q == occ_q) && !vld_s1;
	assign sts.pack_done = (rd_q == occ_q) && !vld_s1 && !vld_s2;

	always_comb begin
		ram_we = 1'b0;
		ram_wa = slot(head_q, wr_q);
		ram_wd = val_s2;
		ram_ra = slot(head_q, rd_q);
		if (cmd.accept) begin
			ram_ra = (opcode == OP_POP_FRONT) ? head_q : slot(head_q, occ_q - CW'(1));
			ram_we = pushing;
			ram_wd = value;
			ram_wa = (opcode == OP_PUSH_FRONT) ? head_dec : slot(head_q, occ_q);
		end else if (cmd.run_pack && vld_s2 && keep) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
			rd_q   <= '0;
			wr_q   <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1 && cmd.run_pack;
			if (issue) begin
				rd_q <= rd_q + CW'(1);
			end
			if (cmd.run_pack && vld_s2 && keep) begin
				wr_q <= wr_q + CW'(1);
			end
			if (cmd.start_pack) begin
				rd_q <= '0;
			end
			if (cmd.pack_end) begin
				occ_q <= wr_q;
			end
			if (cmd.accept) begin
				rd_q   <= '0;
				wr_q   <= '0;
				case (opcode)
					OP_PUSH_FRONT: begin
						if (!full) begin
							head_q <= head_dec;
							occ_q  <= occ_q + CW'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (!full) begin
							occ_q <= occ_q + CW'(1);
						end
					end
					OP_POP_FRONT: begin
						if (!empty) begin
							head_q <= slot(head_q, CW'(1));
							occ_q  <= occ_q - CW'(1);
						end
					end
					OP_POP_BACK: begin
						if (!empty) begin
							occ_q <= occ_q - CW'(1);
						end
					end
					OP_CLEAR: begin
						head_q <= '0;
						occ_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= PW'(rd_sval) * PW'(signed'({1'b0, occ_q}));
			val_s2  <= ram_rd;
		end
		if (vld_s1 && cmd.run_sum) begin
			sum_q <= sum_q + SW'(rd_sval);
		end
		if (cmd.accept) begin
			op_q      <= opcode;
			key_q     <= value;
			sum_q     <= '0;
			res_pop_q <= '0;
			res_rem_q <= '0;
			if ((opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK) && full) begin
				res_st_q <= ST_FULL;
			end else if ((opcode == OP_POP_FRONT || opcode == OP_POP_BACK) && empty) begin
				res_st_q <= ST_EMPTY;
			end else begin
				res_st_q <= ST_OK;
			end
		end
		if (cmd.cap_pop) begin
			res_pop_q <= ram_rd;
		end
		if (cmd.pack_end) begin
			res_rem_q <= gone_ext[6:0];
		end
		if (cmd.load_out) begin
			popped_value  <= signed'(res_pop_q);
			removed_count <= res_rem_q;
			status        <= res_st_q;
		end
	end

endmodule

`default_nettype wire

// ===== src/deque_with_key_removal.sv =====
// ----------------------------------------------------------------------------
// Deque with key removal
// Bounded double-ended queue of signed words in a ring RAM, with in-order
// compaction for key and below-mean removal.
//
//   channel | handshake          | word
//   in      | in_valid/in_stall  | opcode, value
//   out     | out_valid/out_stall| popped_value, removed_count, status
//
// Push, clear and rejected ops go from S_IDLE straight to S_DONE; a pop also
// passes S_POP (RAM read). Key removal runs one S_PACK pass, below-mean removal
// an S_SUM pass then an S_PACK pass, with one RAM read per entry per pass.
// Reset empties the deque; RAM contents are left as they are.
// A result waiting on out_stall holds in the output word while the next word
// is taken in; a second finished result then waits for the output to free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deque_with_key_removal #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         opcode,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      popped_value,
	output logic [6:0]              removed_count,
	output logic [1:0]              status
);
	import dqkr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dqkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	dqkr_dp #(.DEPTH(DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.value         (value),
		.popped_value  (popped_value),
		.removed_count (removed_count),
		.status        (status)
	);

endmodule

`default_nettype wire

// ===== src/dqkr_checker.sv =====
// ----------------------------------------------------------------------------
// Deque port checker
// Port-level properties of the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "deque_with_key_removal_assert.svh"

module dqkr_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] popped_value,
	input wire logic [6:0]         removed_count,
	input wire logic [1:0]         status
);
	import dqkr_pkg::*;

	`DQKR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(popped_value) && $stable(status), "stalled output word changed")
	`DQKR_ASSERT_NOW(a_status_code, out_valid,
		status == ST_OK || status == ST_EMPTY || status == ST_FULL, "bad status code")
	`DQKR_ASSERT_NOW(a_fail_quiet, out_valid && status != ST_OK,
		popped_value == 0 && removed_count == 0, "failed op carries data")
	`DQKR_ASSERT_NOW(a_rm_no_pop, out_valid && removed_count != 0,
		popped_value == 0 && status == ST_OK, "removal word carries popped value")

endmodule

bind deque_with_key_removal dqkr_checker u_dqkr_checker (.*);

`default_nettype wire
